// ===== hw/rtl/mgp_pkg.sv =====
// shared types, constants and prediction helper of the median gradient predictor
package mgp_pkg;

    // line buffer geometry
    localparam int ROW_BYTES_MAX = 4096;
    localparam int COL_W         = $clog2(ROW_BYTES_MAX);
    localparam int LEN_W         = COL_W + 1;
    localparam int DATA_W        = 8;
    localparam int CFG_IDX_W     = 2;

    localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(1024);
    localparam logic [LEN_W-1:0] ROW_LENGTH_MAX   = LEN_W'(ROW_BYTES_MAX);
    localparam logic [LEN_W-1:0] ROW_LENGTH_MIN   = LEN_W'(1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_LENGTH = 2'd0,
        CFG_DIRECTION  = 2'd1
    } cfg_index_t;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // position of the current row within the plane
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_LATER  = 2'd2
    } row_phase_t;

    // control carried alongside the line buffer read
    typedef struct packed {
        logic              use_above;
        logic              c_is_b;
        logic              last;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] din;
    } stage_ctl_t;

    // median of left, above and left+above-aboveleft, low byte
    function automatic logic [DATA_W-1:0] med_predict(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] c
    );
        logic signed [DATA_W+1:0] sa;
        logic signed [DATA_W+1:0] sb;
        logic signed [DATA_W+1:0] sg;
        logic signed [DATA_W+1:0] lo;
        logic signed [DATA_W+1:0] hi;
        sa = signed'({2'b00, a});
        sb = signed'({2'b00, b});
        sg = sa + sb - signed'({2'b00, c});
        lo = (sa <= sb) ? sa : sb;
        hi = (sa >= sb) ? sa : sb;
        lo = (lo >= sg) ? lo : sg;
        lo = (lo <= hi) ? lo : hi;
        return lo[DATA_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/median_gradient_predictor_unit.sv =====
// Pipeline: the line buffer is read as a request enters stage one; the
// result is registered at the output as stage one advances, which is also
// when the byte is written back, with a bypass when that write hits the
// column being read. Throughput: one byte per cycle while results are taken.
// Reset: column, row phase, neighbour bytes and pipeline valids clear; row
// length returns to 1024 and direction to encode. The line buffer is not
// cleared: bytes above are written first unless a row outgrows the one above.
module median_gradient_predictor_unit
    import mgp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [DATA_W-1:0]    s_data_in,
    input  logic                 s_last_in_frame,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_data_out,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    // configuration
    logic [LEN_W-1:0] row_length_reg;
    logic             direction_reg;

    // position tracking at acceptance
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    row_phase_t       phase_reg;
    row_phase_t       phase_next;

    // stage after the buffer read
    logic             valid1_reg;
    stage_ctl_t       ctl1_reg;
    logic             fwd_valid_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    // neighbour bytes
    logic [DATA_W-1:0] left_reg;
    logic [DATA_W-1:0] above_left_reg;

    // output register
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;

    logic              s_accept;
    logic              advance;
    logic [LEN_W-1:0]  eff_len;
    logic              end_row;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] above_left;
    logic [DATA_W-1:0] pred;
    logic [DATA_W-1:0] pixel;
    logic [DATA_W-1:0] result;

    assign cfg_ready = 1'b1;
    assign advance   = valid1_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !valid1_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data_out = m_data_reg;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= ROW_LENGTH_RESET;
            direction_reg  <= DIR_ENCODE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ROW_LENGTH: row_length_reg <= cfg_data;
                CFG_DIRECTION:  direction_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective row length, zero taken as one and clamped to the buffer size
    always_comb begin
        if (row_length_reg == '0) begin
            eff_len = ROW_LENGTH_MIN;
        end else if (row_length_reg > ROW_LENGTH_MAX) begin
            eff_len = ROW_LENGTH_MAX;
        end else begin
            eff_len = row_length_reg;
        end
        end_row = ({1'b0, col_reg} + LEN_W'(1)) >= eff_len;
    end

    // column and phase advance
    always_comb begin
        col_next   = col_reg;
        phase_next = phase_reg;
        if (s_last_in_frame) begin
            col_next   = '0;
            phase_next = PH_FIRST;
        end else if (end_row) begin
            col_next = '0;
            unique case (phase_reg)
                PH_FIRST:  phase_next = PH_SECOND;
                PH_SECOND: phase_next = PH_LATER;
                PH_LATER:  phase_next = PH_LATER;
                default:   phase_next = PH_LATER;
            endcase
        end else begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            phase_reg <= PH_FIRST;
        end else if (s_accept) begin
            col_reg   <= col_next;
            phase_reg <= phase_next;
        end
    end

    // stage one control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (s_accept) begin
            valid1_reg <= 1'b1;
        end else if (advance) begin
            valid1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ctl1_reg.use_above <= (phase_reg != PH_FIRST);
            ctl1_reg.c_is_b    <= (phase_reg == PH_SECOND) && (col_reg == '0);
            ctl1_reg.last      <= s_last_in_frame;
            ctl1_reg.col       <= col_reg;
            ctl1_reg.din       <= s_data_in;
        end
    end

    // bypass when the write back hits the column being read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_valid_reg <= advance && (ctl1_reg.col == col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_data_reg <= pixel;
        end
    end

    // line buffer
    mgp_row_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (COL_W)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (advance),
        .wr_addr (ctl1_reg.col),
        .wr_data (pixel),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rdata)
    );

    // prediction, and residual (encode) or reconstructed byte (decode)
    always_comb begin
        above      = fwd_valid_reg ? fwd_data_reg : ram_rdata;
        above_left = ctl1_reg.c_is_b ? above : above_left_reg;
        if (ctl1_reg.use_above) begin
            pred = med_predict(left_reg, above, above_left);
        end else begin
            pred = left_reg;
        end
        if (direction_reg == DIR_DECODE) begin
            pixel  = ctl1_reg.din + pred;
            result = pixel;
        end else begin
            pixel  = ctl1_reg.din;
            result = ctl1_reg.din - pred;
        end
    end

    // neighbour bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= '0;
            above_left_reg <= '0;
        end else if (advance) begin
            if (ctl1_reg.last) begin
                left_reg       <= '0;
                above_left_reg <= '0;
            end else begin
                left_reg <= pixel;
                if (ctl1_reg.use_above) begin
                    above_left_reg <= above;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    // a stalled item keeps its column
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid1_reg && !advance) |=> (valid1_reg && $stable(ctl1_reg.col)))
        else $error("stage one item changed while stalled");

    // end of plane returns to the first column of the first row
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_last_in_frame) |=> (col_reg == '0 && phase_reg == PH_FIRST))
        else $error("position not cleared after end of plane");

    // bypassed byte equals the one written back in the same cycle
    a_bypass_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && advance && ctl1_reg.col == col_reg)
        |=> (fwd_valid_reg && fwd_data_reg == $past(pixel)))
        else $error("line buffer bypass lost the written byte");

    // an accepted item always reaches stage one
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> valid1_reg)
        else $error("accepted item missing from stage one");

endmodule

// ===== hw/rtl/mgp_row_ram.sv =====
// single port-pair line buffer memory with registered read data
module mgp_row_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/median_gradient_predictor_unit_test.sv =====
// self-checking testbench of the median gradient predictor: random stimulus, scoreboard
module median_gradient_predictor_unit_test
    import mgp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 800000;
    localparam int RANDOM_REQUESTS = 1100;
    localparam int PRINT_LIMIT     = 30;
    localparam int TAIL_CYCLES     = 8;

    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    // receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_BURSTY,
        RX_TOGGLE
    } rx_pattern_t;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              last;
    } pixel_req_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [DATA_W-1:0]    s_data_in = '0;
    logic                 s_last_in_frame = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [DATA_W-1:0]    m_data_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ROW_LENGTH;
    logic [LEN_W-1:0]     cfg_data = '0;

    median_gradient_predictor_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_in       (s_data_in),
        .s_last_in_frame (s_last_in_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_out      (m_data_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pixel_req_t        pending_reqs[$];
    logic [DATA_W-1:0] expected_bytes[$];

    // predictor state: line buffer, neighbours, position and register copies
    logic [DATA_W-1:0] line_buf [ROW_BYTES_MAX];
    logic [DATA_W-1:0] left_px = '0;
    logic [DATA_W-1:0] above_left_px = '0;
    int unsigned       col_cnt = 0;
    row_phase_t        row_phase = PH_FIRST;
    logic [LEN_W-1:0]  len_setting = ROW_LENGTH_RESET;
    logic              dir_setting = DIR_ENCODE;

    int unsigned cycle_count = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_planes = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned fail_count = 0;

    int          burst_left = 1;
    int          gap_left = 0;
    rx_pattern_t rx_pattern = RX_ALWAYS;
    int          pattern_left = 0;
    int          hold_left = 0;

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        fail_count++;
    endtask

    // row length as the block applies it
    function automatic int unsigned eff_len(input logic [LEN_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        if (v > ROW_BYTES_MAX) begin
            return ROW_BYTES_MAX;
        end
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] mid_of_three(input int x, input int y, input int z);
        int lo;
        int hi;
        int m;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        if (z < lo) begin
            m = lo;
        end else if (z > hi) begin
            m = hi;
        end else begin
            m = z;
        end
        return m[DATA_W-1:0];
    endfunction

    // expected output byte for one accepted request, advances the predictor
    task automatic predict_byte(input logic [DATA_W-1:0] din, input logic last,
                                output logic [DATA_W-1:0] res);
        int unsigned       len;
        int unsigned       col;
        int                a;
        int                b;
        int                c;
        logic [DATA_W-1:0] guess;
        logic [DATA_W-1:0] px;
        len = eff_len(len_setting);
        col = col_cnt % ROW_BYTES_MAX;
        if (row_phase == PH_FIRST) begin
            guess = left_px;
        end else begin
            a = left_px;
            b = line_buf[col];
            // start of the second row: above-left is taken as above
            c = (row_phase == PH_SECOND && col_cnt == 0) ? b : int'(above_left_px);
            guess = mid_of_three(a, b, a + b - c);
            above_left_px = line_buf[col];
        end
        if (dir_setting == DIR_ENCODE) begin
            px = din;
            res = din - guess;
        end else begin
            px = din + guess;
            res = px;
        end
        line_buf[col] = px;
        left_px = px;
        // position update: end of plane, end of row, or next column
        if (last) begin
            col_cnt = 0;
            row_phase = PH_FIRST;
            left_px = '0;
            above_left_px = '0;
        end else if (col_cnt + 1 >= len) begin
            col_cnt = 0;
            if (row_phase != PH_LATER) begin
                row_phase = row_phase_t'(row_phase + 2'd1);
            end
        end else begin
            col_cnt++;
        end
    endtask

    // driver: bursts of requests separated by random gaps
    always @(posedge aclk) begin : drive_requests
        pixel_req_t        nxt;
        logic [DATA_W-1:0] want;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_byte(s_data_in, s_last_in_frame, want);
                expected_bytes.push_back(want);
                n_accepted++;
            end
            if (s_valid && !s_ready) begin
                // hold the request until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                s_valid <= 1'b1;
                s_data_in <= nxt.data;
                s_last_in_frame <= nxt.last;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = 1;
                        2: gap_left = $urandom_range(1, 4);
                        default: gap_left = $urandom_range(5, 12);
                    endcase
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest prediction, then pick ready
    always @(posedge aclk) begin : check_results
        logic [DATA_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("result 0x%02h with no request outstanding",
                                              m_data_out));
                end else begin
                    want = expected_bytes.pop_front();
                    n_checked++;
                    if (m_data_out !== want) begin
                        report_mismatch($sformatf("data_out 0x%02h, expected 0x%02h",
                                                  m_data_out, want));
                    end
                end
            end
            // stall pattern changes every stretch of cycles
            if (pattern_left <= 0) begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(20, 200);
            end else begin
                pattern_left--;
            end
            case (rx_pattern)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 2) != 0);
                RX_BURSTY: begin
                    if (hold_left > 0) begin
                        hold_left--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) begin
                            hold_left = $urandom_range(1, 16);
                        end
                    end
                end
                default: m_ready <= !m_ready;
            endcase
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_bytes.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_req(input logic [DATA_W-1:0] data, input logic last);
        pixel_req_t r;
        r.data = data;
        r.last = last;
        pending_reqs.push_back(r);
        if (last) begin
            n_planes++;
        end
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ROW_LENGTH) begin
            len_setting = value;
        end else if (idx == CFG_DIRECTION) begin
            dir_setting = value[0];
        end
        n_cfg_writes++;
    endtask

    task automatic write_direction(input logic dir);
        logic [LEN_W-1:0] value;
        // upper bits carry junk, only bit 0 counts
        value = LEN_W'($urandom);
        value[0] = dir;
        write_reg(CFG_DIRECTION, value);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_bytes.size() != 0);
    endtask

    // a run of bytes, smooth gradients or noise, optionally closing the plane
    task automatic queue_plane(input int unsigned n_bytes, input bit close, input bit smooth);
        logic [DATA_W-1:0] v;
        v = DATA_W'($urandom);
        for (int unsigned i = 0; i < n_bytes; i++) begin
            if (smooth) begin
                v = v + DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
            end else begin
                v = DATA_W'($urandom);
            end
            if ($urandom_range(0, 30) == 0) begin
                v = ($urandom_range(0, 1) != 0) ? '1 : '0;
            end
            push_req(v, close && (i == n_bytes - 1));
        end
    endtask

    task automatic pick_row_length();
        logic [LEN_W-1:0] v;
        case ($urandom_range(0, 11))
            0: v = '0;
            1: v = ROW_LENGTH_MIN;
            2: v = LEN_W'(2);
            3, 4, 5: v = LEN_W'($urandom_range(3, 12));
            6, 7, 8: v = LEN_W'($urandom_range(13, 40));
            9: v = LEN_W'($urandom_range(41, 150));
            10: v = ROW_LENGTH_MAX;
            default: v = LEN_W'($urandom_range(ROW_BYTES_MAX + 1, (1 << LEN_W) - 1));
        endcase
        // a longer row past the first row would reach beyond the row above
        if (row_phase != PH_FIRST && eff_len(v) > eff_len(len_setting)) begin
            v = len_setting;
        end
        write_reg(CFG_ROW_LENGTH, v);
    endtask

    initial begin : stimulus
        int unsigned random_sent;
        int unsigned len;
        int unsigned n_bytes;
        int unsigned rows;
        bit          close;
        random_sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings, plane left open in mid-row
        push_req(8'h00, 1'b0);
        push_req(8'hff, 1'b0);
        push_req(8'h80, 1'b0);
        wait_idle();

        // shorter row mid-plane: column already past the end, row ends after next byte
        write_reg(CFG_ROW_LENGTH, LEN_W'(2));
        @(negedge aclk);
        push_req(8'h7f, 1'b0);
        push_req(8'h01, 1'b0);
        push_req(8'hfe, 1'b1);
        wait_idle();

        // four-byte rows: first row, second row start, later rows, byte extremes
        write_reg(CFG_ROW_LENGTH, LEN_W'(4));
        write_direction(DIR_ENCODE);
        @(negedge aclk);
        push_req(8'hff, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'h7f, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'hff, 1'b0);
        push_req(8'h01, 1'b0);
        push_req(8'hfe, 1'b0);
        push_req(8'hff, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'hff, 1'b0);
        push_req(8'h00, 1'b1);
        wait_idle();

        // decode with zero row length (acts as one), plane end mid-stream
        write_direction(DIR_DECODE);
        write_reg(CFG_ROW_LENGTH, '0);
        @(negedge aclk);
        push_req(8'hff, 1'b0);
        push_req(8'h01, 1'b0);
        push_req(8'h00, 1'b1);
        push_req(8'h80, 1'b0);
        push_req(8'h7f, 1'b1);
        wait_idle();

        // row length above the maximum clamps
        write_reg(CFG_ROW_LENGTH, '1);
        write_reg(CFG_SPARE, LEN_W'($urandom));
        @(negedge aclk);
        push_req(8'h55, 1'b0);
        push_req(8'haa, 1'b1);
        wait_idle();

        // a short plane at the largest row length, first row only
        write_reg(CFG_ROW_LENGTH, ROW_LENGTH_MAX);
        write_direction(DIR_ENCODE);
        @(negedge aclk);
        queue_plane(64, 1'b1, 1'b1);
        wait_idle();

        // random phases: mostly whole planes, some noise and unfinished planes
        while (random_sent < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 2) != 0) begin
                pick_row_length();
            end
            if ($urandom_range(0, 1) != 0) begin
                write_direction(1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 40) == 0) begin
                write_reg(CFG_SPARE, LEN_W'($urandom));
            end
            len = eff_len(len_setting);
            @(negedge aclk);
            if ($urandom_range(0, 9) < 2) begin
                n_bytes = $urandom_range(1, 30);
                for (int unsigned i = 0; i < n_bytes; i++) begin
                    push_req(DATA_W'($urandom), $urandom_range(0, 9) == 0);
                end
            end else begin
                close = ($urandom_range(0, 4) != 0);
                if (len > 256) begin
                    n_bytes = $urandom_range(1, 40);
                    close = 1'b1;
                end else begin
                    rows = $urandom_range(1, (len <= 8) ? 12 : ((len <= 40) ? 5 : 2));
                    n_bytes = rows * len;
                    if ($urandom_range(0, 3) == 0) begin
                        n_bytes += $urandom_range(0, len - 1);
                    end
                end
                queue_plane(n_bytes, close, $urandom_range(0, 2) != 0);
            end
            random_sent += n_bytes;
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        $display("%0d requests in %0d planes, %0d register writes, both directions",
                 n_accepted, n_planes, n_cfg_writes);
        $display("%0d results checked, %0d mismatches", n_checked, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mgp_pkg.sv
hw/rtl/mgp_row_ram.sv
hw/rtl/median_gradient_predictor_unit.sv
sim/median_gradient_predictor_unit_test.sv
